// ===== rtl/obsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Obstacle and battery qualifier package
// Shared types, register codes and widths for the safety qualifier block.
// ----------------------------------------------------------------------------
`default_nettype none

package obsq_pkg;

  localparam int TIME_W = 32;
  localparam int AGE_W  = 16;
  localparam int MEAS_W = 16;
  localparam int RUN_W  = 8;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 8;

  localparam logic [TIME_W-1:0] NONE_TIME = '1;

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_MAX_SAMPLE_AGE    = 8'd0,
    REG_STOP_DIST         = 8'd1,
    REG_CLEAR_DIST        = 8'd2,
    REG_NEAR_NEEDED       = 8'd3,
    REG_CLEAR_NEEDED      = 8'd4,
    REG_BATT_WARN         = 8'd5,
    REG_BATT_SHUTDOWN     = 8'd6,
    REG_SHUTDOWN_NEEDED   = 8'd7
  } obsq_reg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
    logic              dist_ok;
    logic [AGE_W-1:0]  dist_age;
    logic [MEAS_W-1:0] dist_value;
    logic              batt_ok;
    logic [AGE_W-1:0]  batt_age;
    logic [MEAS_W-1:0] batt_level;
  } obsq_in_t;

  typedef struct packed {
    logic             obstacle_now;
    logic             obstacle_began;
    logic [AGE_W-1:0] decision_age_out;
    logic             low_battery;
    logic             shutdown_event;
  } obsq_out_t;

  // One reading as seen by the freshness filter.
  typedef struct packed {
    logic             ok;
    logic [AGE_W-1:0] age;
  } obsq_sample_t;

endpackage

`default_nettype wire

// ===== rtl/obsq_fresh.sv =====
// ----------------------------------------------------------------------------
// Sample freshness filter
// Holds the capture time of the last fresh reading and flags new fresh ones.
// ----------------------------------------------------------------------------
`default_nettype none

module obsq_fresh
  import obsq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [TIME_W-1:0] now_time,
  input  wire obsq_sample_t      sample,
  input  wire logic [AGE_W-1:0]  max_sample_age,
  output logic                   fresh
);

  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] captured;

  assign captured = now_time - {{(TIME_W-AGE_W){1'b0}}, sample.age};

  // All ones in the register means no reading taken yet.
  assign fresh = sample.ok && (sample.age <= max_sample_age) &&
                 ((last_time == NONE_TIME) || (captured != last_time));

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= NONE_TIME;
    end else if (step && fresh) begin
      last_time <= captured;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/obstacle_and_battery_safety_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// Obstacle and battery safety qualifier
// Qualifies distance and battery readings and produces stop and shutdown flags.
// ----------------------------------------------------------------------------
// One request carries a tick: the current time and a distance and a battery
// reading, each with a valid bit and an age. Every request gives exactly one
// result. The block takes a request in every cycle while results are taken; a
// request passes an input register and then a result register before its
// result shows on the outputs. The result register lets the next request in
// while a result waits. Stalls on the output side back up through in_ready.
// Configuration writes take effect at once and belong in periods with no
// request in flight.
`default_nettype none

module obstacle_and_battery_safety_qualifier_unit
  import obsq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire obsq_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output obsq_out_t             out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  // Configuration registers.
  logic [AGE_W-1:0]  max_sample_age;
  logic [MEAS_W-1:0] stop_dist;
  logic [MEAS_W-1:0] clear_dist;
  logic [RUN_W-1:0]  near_needed;
  logic [RUN_W-1:0]  clear_needed;
  logic [MEAS_W-1:0] batt_warn;
  logic [MEAS_W-1:0] batt_shutdown;
  logic [RUN_W-1:0]  shutdown_needed;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sample_age  <= AGE_W'(200);
      stop_dist       <= MEAS_W'(20);
      clear_dist      <= MEAS_W'(30);
      near_needed     <= RUN_W'(3);
      clear_needed    <= RUN_W'(3);
      batt_warn       <= MEAS_W'(6800);
      batt_shutdown   <= MEAS_W'(6400);
      shutdown_needed <= RUN_W'(5);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_SAMPLE_AGE:  max_sample_age  <= cfg_data[AGE_W-1:0];
        REG_STOP_DIST:       stop_dist       <= cfg_data[MEAS_W-1:0];
        REG_CLEAR_DIST:      clear_dist      <= cfg_data[MEAS_W-1:0];
        REG_NEAR_NEEDED:     near_needed     <= cfg_data[RUN_W-1:0];
        REG_CLEAR_NEEDED:    clear_needed    <= cfg_data[RUN_W-1:0];
        REG_BATT_WARN:       batt_warn       <= cfg_data[MEAS_W-1:0];
        REG_BATT_SHUTDOWN:   batt_shutdown   <= cfg_data[MEAS_W-1:0];
        REG_SHUTDOWN_NEEDED: shutdown_needed <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register and result register.
  logic      s1_valid;
  obsq_in_t  s1_data;
  logic      advance;
  obsq_out_t result_next;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (!out_valid || out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (advance) begin
      out_data <= result_next;
    end
  end

  // Freshness filters.
  logic         dist_fresh;
  logic         batt_fresh;
  obsq_sample_t dist_sample;
  obsq_sample_t batt_sample;

  assign dist_sample = {s1_data.dist_ok, s1_data.dist_age};
  assign batt_sample = {s1_data.batt_ok, s1_data.batt_age};

  obsq_fresh u_dist_fresh (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .now_time       (s1_data.now_time),
    .sample         (dist_sample),
    .max_sample_age (max_sample_age),
    .fresh          (dist_fresh)
  );

  obsq_fresh u_batt_fresh (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .now_time       (s1_data.now_time),
    .sample         (batt_sample),
    .max_sample_age (max_sample_age),
    .fresh          (batt_fresh)
  );

  // Qualifier state.
  logic [RUN_W-1:0] near_run, near_run_next;
  logic [RUN_W-1:0] clear_run, clear_run_next;
  logic             obstacle_latched, obstacle_latched_next;
  logic [AGE_W-1:0] held_age, held_age_next;
  logic [RUN_W-1:0] low_run, low_run_next;
  logic             shutdown_done, shutdown_done_next;
  logic [RUN_W-1:0] near_inc, clear_inc, low_inc;
  logic             began;
  logic             shut;

  // Runs saturate at the needed count so they never wrap.
  assign near_inc  = (near_run < near_needed) ? near_run + 1'b1 : near_run;
  assign clear_inc = (clear_run < clear_needed) ? clear_run + 1'b1 : clear_run;
  assign low_inc   = (low_run < shutdown_needed) ? low_run + 1'b1 : low_run;

  always_comb begin
    near_run_next         = near_run;
    clear_run_next        = clear_run;
    obstacle_latched_next = obstacle_latched;
    held_age_next         = held_age;
    began                 = 1'b0;
    if (dist_fresh) begin
      held_age_next = s1_data.dist_age;
      if (s1_data.dist_value < stop_dist) begin
        clear_run_next = '0;
        near_run_next  = near_inc;
        if (!obstacle_latched && (near_inc >= near_needed)) begin
          obstacle_latched_next = 1'b1;
          began                 = 1'b1;
        end
      end else if (s1_data.dist_value >= clear_dist) begin
        near_run_next  = '0;
        clear_run_next = clear_inc;
        if (obstacle_latched && (clear_inc >= clear_needed)) begin
          obstacle_latched_next = 1'b0;
        end
      end else begin
        near_run_next  = '0;
        clear_run_next = '0;
      end
    end
  end

  always_comb begin
    low_run_next       = low_run;
    shutdown_done_next = shutdown_done;
    shut               = 1'b0;
    if (batt_fresh) begin
      if (s1_data.batt_level <= batt_shutdown) begin
        low_run_next = low_inc;
        if (!shutdown_done && (low_inc >= shutdown_needed)) begin
          shutdown_done_next = 1'b1;
          shut               = 1'b1;
        end
      end else if (s1_data.batt_level > batt_warn) begin
        // Only a reading above the warn line re-arms the report.
        low_run_next       = '0;
        shutdown_done_next = 1'b0;
      end else begin
        low_run_next = '0;
      end
    end
  end

  always_comb begin
    result_next.obstacle_now     = obstacle_latched_next;
    result_next.obstacle_began   = began;
    result_next.decision_age_out = held_age_next;
    result_next.low_battery      = s1_data.batt_ok && (s1_data.batt_level <= batt_warn);
    result_next.shutdown_event   = shut;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      near_run         <= '0;
      clear_run        <= '0;
      obstacle_latched <= 1'b0;
      held_age         <= '0;
      low_run          <= '0;
      shutdown_done    <= 1'b0;
    end else if (advance) begin
      near_run         <= near_run_next;
      clear_run        <= clear_run_next;
      obstacle_latched <= obstacle_latched_next;
      held_age         <= held_age_next;
      low_run          <= low_run_next;
      shutdown_done    <= shutdown_done_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/obsq_checker.sv =====
// ----------------------------------------------------------------------------
// Safety qualifier port checker
// Watches the result stream of the qualifier for flag and pulse consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module obsq_checker
  import obsq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire obsq_out_t out_data
);

  logic out_fire;
  logic prev_obstacle;
  logic prev_shut;

  assign out_fire = out_valid && out_ready;

  // Flags of the last result delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_obstacle <= 1'b0;
      prev_shut     <= 1'b0;
    end else if (out_fire) begin
      prev_obstacle <= out_data.obstacle_now;
      prev_shut     <= out_data.shutdown_event;
    end
  end

  a_began_sets_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.obstacle_began |-> out_data.obstacle_now)
    else $error("obstacle_began without obstacle_now");

  a_began_on_rise: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> (out_data.obstacle_began == (out_data.obstacle_now && !prev_obstacle)))
    else $error("obstacle_began does not match a rise of the obstacle flag");

  a_shutdown_once: assert property (@(posedge clk) disable iff (rst)
    out_fire && prev_shut |-> !out_data.shutdown_event)
    else $error("shutdown reported on two results in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

endmodule

bind obstacle_and_battery_safety_qualifier_unit obsq_checker u_obsq_checker (.*);

`default_nettype wire

// ===== dv/tb_obstacle_and_battery_safety_qualifier_unit.sv =====
// ----------------------------------------------------------------------------
// Obstacle and battery safety qualifier testbench
// Drives tick requests through the valid/ready ports under random idling and
// output back-pressure, predicts every result in a scoreboard that keeps its
// own copy of the registers and qualifier state, and compares each result
// field by field. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb_obstacle_and_battery_safety_qualifier_unit;
  import obsq_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 11;
  localparam int TIMEOUT_CYCLES  = 600000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 8;
  localparam int REG_COUNT       = 8;
  localparam int MAX_INDEX       = 255;
  localparam int FULL_16         = 65535;

  typedef enum int {ZONE_LOW, ZONE_MID, ZONE_HIGH, ZONE_ANY} zone_t;

  // Predicts one result per tick and holds the results still to come.
  class qualifier_scoreboard;
    logic [AGE_W-1:0]  max_age;
    logic [MEAS_W-1:0] stop_dist, clear_dist, warn_mv, shutdown_mv;
    logic [RUN_W-1:0]  near_needed, clear_needed, shutdown_needed;
    logic [TIME_W-1:0] last_dist_cap, last_batt_cap;
    logic [RUN_W-1:0]  near_run, clear_run, low_run;
    logic              obstacle_latched, shutdown_done;
    logic [AGE_W-1:0]  held_age;
    obsq_out_t         expected_q[$];
    int errors, ticks, fresh_dist, fresh_batt, latches, shutdowns;

    function new();
      max_age          = 16'd200;
      stop_dist        = 16'd20;
      clear_dist       = 16'd30;
      near_needed      = 8'd3;
      clear_needed     = 8'd3;
      warn_mv          = 16'd6800;
      shutdown_mv      = 16'd6400;
      shutdown_needed  = 8'd5;
      last_dist_cap    = NONE_TIME;
      last_batt_cap    = NONE_TIME;
      near_run         = '0;
      clear_run        = '0;
      low_run          = '0;
      obstacle_latched = 1'b0;
      shutdown_done    = 1'b0;
      held_age         = '0;
    endfunction

    // The narrow registers keep only the low byte of the written data.
    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MAX_SAMPLE_AGE:  max_age = val;
        REG_STOP_DIST:       stop_dist = val;
        REG_CLEAR_DIST:      clear_dist = val;
        REG_NEAR_NEEDED:     near_needed = val[RUN_W-1:0];
        REG_CLEAR_NEEDED:    clear_needed = val[RUN_W-1:0];
        REG_BATT_WARN:       warn_mv = val;
        REG_BATT_SHUTDOWN:   shutdown_mv = val;
        REG_SHUTDOWN_NEEDED: shutdown_needed = val[RUN_W-1:0];
        default: ;
      endcase
    endfunction

    // All ones as the last capture means none yet, so a capture of all ones
    // never blocks the next reading with the same capture time.
    function bit is_fresh(logic ok, logic [AGE_W-1:0] age, logic [TIME_W-1:0] now,
                          logic [TIME_W-1:0] last);
      logic [TIME_W-1:0] cap;
      cap = now - {{(TIME_W-AGE_W){1'b0}}, age};
      return ok && (age <= max_age) && !(last != NONE_TIME && cap == last);
    endfunction

    function void note_tick(obsq_in_t t);
      obsq_out_t exp;
      logic began, shut, low;
      began = 1'b0;
      shut  = 1'b0;
      ticks++;
      if (is_fresh(t.dist_ok, t.dist_age, t.now_time, last_dist_cap)) begin
        fresh_dist++;
        last_dist_cap = t.now_time - {{(TIME_W-AGE_W){1'b0}}, t.dist_age};
        held_age = t.dist_age;
        if (t.dist_value < stop_dist) begin
          clear_run = '0;
          if (near_run < near_needed) near_run = near_run + 1'b1;
          if (!obstacle_latched && near_run >= near_needed) begin
            obstacle_latched = 1'b1;
            began = 1'b1;
          end
        end else if (t.dist_value >= clear_dist) begin
          near_run = '0;
          if (clear_run < clear_needed) clear_run = clear_run + 1'b1;
          if (obstacle_latched && clear_run >= clear_needed) obstacle_latched = 1'b0;
        end else begin
          near_run  = '0;
          clear_run = '0;
        end
      end
      low = t.batt_ok && (t.batt_level <= warn_mv);
      if (is_fresh(t.batt_ok, t.batt_age, t.now_time, last_batt_cap)) begin
        fresh_batt++;
        last_batt_cap = t.now_time - {{(TIME_W-AGE_W){1'b0}}, t.batt_age};
        if (t.batt_level <= shutdown_mv) begin
          if (low_run < shutdown_needed) low_run = low_run + 1'b1;
          if (!shutdown_done && low_run >= shutdown_needed) begin
            shutdown_done = 1'b1;
            shut = 1'b1;
          end
        end else if (t.batt_level > warn_mv) begin
          low_run = '0;
          shutdown_done = 1'b0;
        end else begin
          low_run = '0;
        end
      end
      latches   += began;
      shutdowns += shut;
      exp.obstacle_now     = obstacle_latched;
      exp.obstacle_began   = began;
      exp.decision_age_out = held_age;
      exp.low_battery      = low;
      exp.shutdown_event   = shut;
      expected_q.push_back(exp);
    endfunction

    function void check_result(obsq_out_t got);
      obsq_out_t exp;
      if (expected_q.size() == 0) begin
        $error("result arrived with no request outstanding: %p", got);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.obstacle_now !== exp.obstacle_now) begin
        $error("obstacle_now: expected %0b, got %0b", exp.obstacle_now, got.obstacle_now);
        errors++;
      end
      if (got.obstacle_began !== exp.obstacle_began) begin
        $error("obstacle_began: expected %0b, got %0b", exp.obstacle_began,
               got.obstacle_began);
        errors++;
      end
      if (got.decision_age_out !== exp.decision_age_out) begin
        $error("decision_age_out: expected %0d, got %0d", exp.decision_age_out,
               got.decision_age_out);
        errors++;
      end
      if (got.low_battery !== exp.low_battery) begin
        $error("low_battery: expected %0b, got %0b", exp.low_battery, got.low_battery);
        errors++;
      end
      if (got.shutdown_event !== exp.shutdown_event) begin
        $error("shutdown_event: expected %0b, got %0b", exp.shutdown_event,
               got.shutdown_event);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  obsq_in_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  obsq_out_t        out_data;
  logic             cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  qualifier_scoreboard sb = new();

  logic [TIME_W-1:0] clock_ms      = '0;
  logic [TIME_W-1:0] prev_dist_cap = '0;
  logic [TIME_W-1:0] prev_batt_cap = '0;
  zone_t             dist_zone     = ZONE_HIGH;
  zone_t             batt_zone     = ZONE_HIGH;
  int                tx_idle_pct   = 0;
  int                rx_stall_pct  = 0;
  int                phases        = 0;
  bit                hold_off_request = 1'b0;
  int                idle_levels[3] = '{0, 15, 45};

  obstacle_and_battery_safety_qualifier_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_tick(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic int idle_cycles(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // A quarter of the picks land on an edge of the range to hit the compares.
  function automatic logic [MEAS_W-1:0] range_value(int lo, int hi);
    int r;
    r = $urandom_range(0, 7);
    if (lo > hi) return MEAS_W'($urandom_range(0, FULL_16));
    if (r == 0) return MEAS_W'(lo);
    if (r == 1) return MEAS_W'(hi);
    return MEAS_W'($urandom_range(hi, lo));
  endfunction

  function automatic zone_t pick_zone();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return ZONE_LOW;
    if (r < 6) return ZONE_MID;
    if (r < 9) return ZONE_HIGH;
    return ZONE_ANY;
  endfunction

  function automatic logic [AGE_W-1:0] pick_age(logic [TIME_W-1:0] prev_cap);
    int r, top;
    logic [TIME_W-1:0] gap;
    r   = $urandom_range(0, 99);
    top = (sb.max_age < 20) ? int'(sb.max_age) : 20;
    gap = clock_ms - prev_cap;
    if (r < 55) return AGE_W'($urandom_range(0, top));
    if (r < 65) return sb.max_age;
    if (r < 72) return sb.max_age + 1'b1;
    // Same capture time as the previous reading of this kind.
    if (r < 85 && gap <= FULL_16) return gap[AGE_W-1:0];
    return AGE_W'($urandom_range(0, FULL_16));
  endfunction

  function automatic obsq_in_t next_tick(int zone_hold);
    obsq_in_t t;
    int r;
    r = $urandom_range(0, 99);
    if (r >= 15) clock_ms = clock_ms + $urandom_range(1, 3);
    else if (r >= 8) clock_ms = $urandom;
    if ($urandom_range(1, zone_hold) == 1) dist_zone = pick_zone();
    if ($urandom_range(1, zone_hold) == 1) batt_zone = pick_zone();
    t.now_time = clock_ms;
    t.dist_ok  = ($urandom_range(0, 9) != 0);
    t.dist_age = pick_age(prev_dist_cap);
    case (dist_zone)
      ZONE_LOW:  t.dist_value = range_value(0, int'(sb.stop_dist) - 1);
      ZONE_MID:  t.dist_value = range_value(int'(sb.stop_dist), int'(sb.clear_dist) - 1);
      ZONE_HIGH: t.dist_value = range_value(int'(sb.clear_dist), FULL_16);
      default:   t.dist_value = MEAS_W'($urandom_range(0, FULL_16));
    endcase
    t.batt_ok  = ($urandom_range(0, 9) != 0);
    t.batt_age = pick_age(prev_batt_cap);
    case (batt_zone)
      ZONE_LOW:  t.batt_level = range_value(0, int'(sb.shutdown_mv));
      ZONE_MID:  t.batt_level = range_value(int'(sb.shutdown_mv) + 1, int'(sb.warn_mv));
      ZONE_HIGH: t.batt_level = range_value(int'(sb.warn_mv) + 1, FULL_16);
      default:   t.batt_level = MEAS_W'($urandom_range(0, FULL_16));
    endcase
    prev_dist_cap = t.now_time - {{(TIME_W-AGE_W){1'b0}}, t.dist_age};
    prev_batt_cap = t.now_time - {{(TIME_W-AGE_W){1'b0}}, t.batt_age};
    return t;
  endfunction

  function automatic obsq_in_t make_tick(logic [TIME_W-1:0] now, logic d_ok,
                                         logic [AGE_W-1:0] d_age, logic [MEAS_W-1:0] d_val,
                                         logic b_ok, logic [AGE_W-1:0] b_age,
                                         logic [MEAS_W-1:0] b_val);
    obsq_in_t t;
    t.now_time   = now;
    t.dist_ok    = d_ok;
    t.dist_age   = d_age;
    t.dist_value = d_val;
    t.batt_ok    = b_ok;
    t.batt_age   = b_age;
    t.batt_level = b_val;
    return t;
  endfunction

  // Returns in the cycle the request is taken; the caller either sends the
  // next one right away or drops in_valid in that same cycle.
  task automatic send_tick(input obsq_in_t t);
    int gap;
    gap = idle_cycles(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] age, stop, clr, near_n, clear_n,
                           warn, shut, shut_n, input int zone_hold, input int num_ticks,
                           input bit hold_off);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(REG_MAX_SAMPLE_AGE, age);
    write_reg(REG_STOP_DIST, stop);
    write_reg(REG_CLEAR_DIST, clr);
    write_reg(REG_NEAR_NEEDED, near_n);
    write_reg(REG_CLEAR_NEEDED, clear_n);
    write_reg(REG_BATT_WARN, warn);
    write_reg(REG_BATT_SHUTDOWN, shut);
    write_reg(REG_SHUTDOWN_NEEDED, shut_n);
    // An index past the register file must leave every setting alone.
    write_reg(IDX_W'($urandom_range(REG_COUNT, MAX_INDEX)),
              CFG_W'($urandom_range(0, FULL_16)));
    cfg_wr_en <= 1'b0;
    tx_idle_pct  = hold_off ? 0 : idle_levels[$urandom_range(0, 2)];
    rx_stall_pct = idle_levels[$urandom_range(0, 2)];
    hold_off_request = hold_off;
    phases++;
    repeat (num_ticks) send_tick(next_tick(zone_hold));
  endtask

  initial begin : result_side
    int stall;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      stall = idle_cycles(rx_stall_pct);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("FAIL obstacle_and_battery_safety_qualifier_unit");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct  = 30;
    rx_stall_pct = 30;

    // Directed ticks on the register values out of reset.
    send_tick(make_tick(32'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0));
    send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
    send_tick(make_tick(32'd100, 1'b1, 16'd0, 16'd5, 1'b1, 16'd0, 16'd6000));
    send_tick(make_tick(32'd100, 1'b1, 16'd0, 16'd5, 1'b1, 16'd0, 16'd6000));
    send_tick(make_tick(32'd101, 1'b1, 16'd1, 16'd5, 1'b1, 16'd201, 16'd6000));
    send_tick(make_tick(32'd302, 1'b1, 16'd200, 16'd0, 1'b1, 16'd200, 16'd6400));
    send_tick(make_tick(32'd303, 1'b1, 16'd0, 16'd19, 1'b1, 16'd0, 16'd0));
    send_tick(make_tick(32'd304, 1'b1, 16'd0, 16'd10, 1'b1, 16'd0, 16'd100));
    send_tick(make_tick(32'd305, 1'b0, 16'd0, 16'd100, 1'b1, 16'd0, 16'd6400));
    // Dead band distance, then a battery reading between the two lines.
    send_tick(make_tick(32'd306, 1'b1, 16'd0, 16'd25, 1'b1, 16'd0, 16'd6000));
    send_tick(make_tick(32'd307, 1'b1, 16'd0, 16'd30, 1'b1, 16'd0, 16'd6600));
    send_tick(make_tick(32'd308, 1'b1, 16'd0, 16'hFFFF, 1'b1, 16'd0, 16'd6000));
    send_tick(make_tick(32'd309, 1'b1, 16'd0, 16'd31, 1'b0, 16'd0, 16'd6000));
    send_tick(make_tick(32'd310, 1'b1, 16'd0, 16'd20, 1'b1, 16'd0, 16'd6801));
    send_tick(make_tick(32'd311, 1'b1, 16'd0, 16'd1, 1'b1, 16'd0, 16'd6400));
    send_tick(make_tick(32'd312, 1'b1, 16'd0, 16'd1, 1'b1, 16'd0, 16'd6400));
    send_tick(make_tick(32'd313, 1'b1, 16'd0, 16'd1, 1'b1, 16'd0, 16'd6400));
    send_tick(make_tick(32'd314, 1'b0, 16'd0, 16'd0, 1'b1, 16'd0, 16'd6400));
    send_tick(make_tick(32'd315, 1'b0, 16'd0, 16'd0, 1'b1, 16'd0, 16'd6400));
    // A capture time of all ones is stored, yet the same capture counts again.
    send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 16'd0, 16'd50, 1'b1, 16'd0, 16'd7000));
    send_tick(make_tick(32'hFFFF_FFFF, 1'b1, 16'd0, 16'd50, 1'b1, 16'd0, 16'd7000));
    send_tick(make_tick(32'd4, 1'b1, 16'd5, 16'd50, 1'b1, 16'd5, 16'd7000));
    send_tick(make_tick(32'h8000_0000, 1'b1, 16'd200, 16'd40, 1'b1, 16'd199, 16'd6801));

    // Reset values again, with the long output hold-off.
    run_phase(16'd200, 16'd20, 16'd30, 16'd3, 16'd3, 16'd6800, 16'd6400, 16'd5, 12, 100, 1'b1);
    run_phase(16'd50, 16'd100, 16'd200, 16'd1, 16'd2, 16'd7000, 16'd6000, 16'd2, 6, 100, 1'b0);
    // Run lengths of zero, written with junk in the upper byte.
    run_phase(16'd300, 16'd1000, 16'd2000, 16'hFF00, 16'h0100, 16'd7200, 16'd6900, 16'hAB00,
              8, 100, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF, 16'd255,
              400, 600, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 5, 100, 1'b0);
    // Crossed thresholds on both the distance and the battery side.
    run_phase(16'd150, 16'd500, 16'd100, 16'd4, 16'd4, 16'd6000, 16'd7000, 16'd3,
              10, 100, 1'b0);
    run_phase(CFG_W'($urandom_range(0, FULL_16)), CFG_W'($urandom_range(0, FULL_16)),
              CFG_W'($urandom_range(0, FULL_16)), CFG_W'($urandom_range(1, 6)),
              CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(0, FULL_16)),
              CFG_W'($urandom_range(0, FULL_16)), CFG_W'($urandom_range(1, 6)),
              8, 100, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings; %0d fresh distance and %0d fresh",
             sb.ticks, phases + 1, sb.fresh_dist, sb.fresh_batt);
    $display("battery readings, %0d obstacle latches, %0d shutdown reports.",
             sb.latches, sb.shutdowns);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS obstacle_and_battery_safety_qualifier_unit");
    end else begin
      $display("FAIL obstacle_and_battery_safety_qualifier_unit");
    end
    $finish;
  end

endmodule

// ===== obstacle_and_battery_safety_qualifier_unit.f =====
rtl/obsq_pkg.sv
rtl/obsq_fresh.sv
rtl/obstacle_and_battery_safety_qualifier_unit.sv
rtl/obsq_checker.sv
dv/tb_obstacle_and_battery_safety_qualifier_unit.sv
